[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Screen geometry, character codes, payload structs and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    // Fixed field widths of the item interface.
    localparam int POS_W  = 11;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE    = 8'd10;
    localparam logic [BYTE_W-1:0] SPACE_CODE      = 8'd32;
    localparam logic [BYTE_W-1:0] RESET_ATTRIBUTE = 8'h02;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] char_code;
        logic [POS_W-1:0]  read_address;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [BYTE_W-1:0] read_char;
        logic [BYTE_W-1:0] read_attribute;
    } out_item_t;

    typedef struct packed {
        logic exec;        // execute the item on the input channel
        logic init_step;   // write one reset cell during the power-up clear
        logic copy_step;   // one step of the scroll copy
        logic clear_step;  // write one blank cell of the bottom row
        logic load_out;    // load the result register
    } ctl_cmd_t;

    typedef struct packed {
        logic scroll;      // the item on the input channel scrolls the screen
        logic copy_last;   // sweep counter sits on the final copy step
        logic sweep_last;  // sweep counter sits on the last cell
    } dp_status_t;

endpackage

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer: character console with scrolling screen store
// Top level joining the sequencing controller to the screen datapath.
// ----------------------------------------------------------------------------
// Each transaction on the input channel either puts a character at the cursor
// or reads one screen cell, and each produces exactly one result transaction
// carrying the linear cursor position and, for reads, the cell's character and
// attribute. An ordinary put or read is accepted and executed against the
// screen store in the IDLE state, and its result is loaded into the output
// register from the DONE state once that register is free; the next item is
// accepted in the cycle after that, and the output register lets it be taken
// while the result still waits downstream. A put that moves the cursor past
// the last row scrolls the screen through the store's single write port, one
// cell per cycle: a copy pass moves every row below the first up by one row,
// then the bottom row is blanked with the current attribute.
// After reset the store is swept to spaces with attribute 0x02, one cell per
// cycle, and no item is accepted until the sweep finishes.
// The attribute register can be written at any time through the configuration
// channel, which is always ready; it is meant to be written while idle.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tcw_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tcw_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tcw_pkg::BYTE_W-1:0]  cfg_data
);

    tcw_pkg::ctl_cmd_t   cmd;
    tcw_pkg::dp_status_t status;

    // The attribute register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    tcw_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    // One item is in work at a time: after an accepted transaction the input
    // channel closes until the result has been loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is still in work");

    // A new result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register loaded while holding an untaken result");

    // The store is driven by at most one activity per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec, cmd.init_step, cmd.copy_step, cmd.clear_step}))
        else $error("conflicting screen store commands");

    // The bottom-row clear always follows a completed copy pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step && !$past(cmd.clear_step) |-> $past(cmd.copy_step))
        else $error("scroll clear started without a copy pass");

endmodule

[design/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath: screen store, cursor and result register
// Holds the character store, the cursor, the attribute register, the sweep
// counter used for clearing and scrolling, and the output register.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::in_item_t           in_data,
    input  logic                        cfg_valid,
    input  logic [tcw_pkg::BYTE_W-1:0]  cfg_data,
    input  tcw_pkg::ctl_cmd_t           cmd,
    output tcw_pkg::dp_status_t         status,
    output tcw_pkg::out_item_t          out_data
);

    localparam int AW = tcw_pkg::ADDR_W;

    logic [15:0]                  mem [tcw_pkg::CELLS];
    logic [15:0]                  rdata_reg;

    logic [tcw_pkg::COL_W-1:0]    col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [tcw_pkg::BYTE_W-1:0]   attr_reg;
    logic [AW-1:0]                sweep_reg, sweep_next;
    logic                         hit_reg, hit_next;
    tcw_pkg::out_item_t           out_reg;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [15:0]                  wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;

    logic                         is_put;
    logic                         is_newline;
    logic                         at_row_end;
    logic                         at_last_row;
    logic                         line_break;
    logic                         in_range;

    assign is_put      = (in_data.opcode == tcw_pkg::OP_PUT);
    assign is_newline  = (in_data.char_code == tcw_pkg::NEWLINE_CODE);
    assign at_row_end  = (col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
    assign at_last_row = (row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    assign line_break  = is_put && (is_newline || at_row_end);
    assign in_range    = (32'(in_data.read_address) < tcw_pkg::CELLS);

    assign status.scroll     = line_break && at_last_row;
    assign status.copy_last  = (sweep_reg == AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS));
    assign status.sweep_last = (sweep_reg == AW'(tcw_pkg::CELLS - 1));

    // Memory port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = {attr_reg, in_data.char_code};
        rd_en   = 1'b0;
        rd_addr = AW'(in_data.read_address);
        if (cmd.exec)
        begin
            wr_en = is_put && !is_newline;
            rd_en = !is_put && in_range;
        end
        else if (cmd.init_step)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = {tcw_pkg::RESET_ATTRIBUTE, tcw_pkg::SPACE_CODE};
        end
        else if (cmd.copy_step)
        begin
            // Read a cell one row below, write the one read last cycle.
            wr_en   = (sweep_reg != '0);
            wr_addr = sweep_reg - AW'(1);
            wr_data = rdata_reg;
            rd_en   = !status.copy_last;
            rd_addr = sweep_reg + AW'(tcw_pkg::COLUMNS);
        end
        else if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg;
            wr_data = {attr_reg, tcw_pkg::SPACE_CODE};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Cursor update for an executed put, and the read-hit flag for every executed item.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        pos_next = pos_reg;
        hit_next = hit_reg;
        if (cmd.exec)
        begin
            hit_next = !is_put && in_range;
            if (line_break)
            begin
                col_next = '0;
                if (at_last_row)
                begin
                    pos_next = AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
                end
                else
                begin
                    row_next = row_reg + tcw_pkg::ROW_W'(1);
                    if (is_newline)
                    begin
                        pos_next = pos_reg + AW'(tcw_pkg::COLUMNS) - AW'(col_reg);
                    end
                    else
                    begin
                        pos_next = pos_reg + AW'(1);
                    end
                end
            end
            else if (is_put)
            begin
                col_next = col_reg + tcw_pkg::COL_W'(1);
                pos_next = pos_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.init_step || cmd.clear_step)
        begin
            sweep_next = status.sweep_last ? '0 : sweep_reg + AW'(1);
        end
        else if (cmd.copy_step && !status.copy_last)
        begin
            sweep_next = sweep_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            pos_reg   <= '0;
            sweep_reg <= '0;
            attr_reg  <= tcw_pkg::RESET_ATTRIBUTE;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            pos_reg   <= pos_next;
            sweep_reg <= sweep_next;
            if (cfg_valid)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        if (cmd.load_out)
        begin
            out_reg.cursor_position <= tcw_pkg::POS_W'(pos_reg);
            out_reg.read_char       <= hit_reg ? rdata_reg[7:0]  : '0;
            out_reg.read_attribute  <= hit_reg ? rdata_reg[15:8] : '0;
        end
    end

    assign out_data = out_reg;

endmodule

[design/tcw_controller.sv]
// ----------------------------------------------------------------------------
// tcw_controller: sequencing state machine
// Runs the power-up clear, accepts items, walks the scroll copy and clear,
// and hands results to the output register.
// ----------------------------------------------------------------------------
module tcw_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tcw_pkg::dp_status_t  status,
    output tcw_pkg::ctl_cmd_t    cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_COPY  = 3'd2;
    localparam logic [2:0] ST_CLEAR = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = status.scroll ? ST_COPY : ST_DONE;
                end
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[tb/text_console_writer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb: self-checking bench for the text console writer
// Streams character puts and cell reads into the console, keeps a shadow
// screen, cursor and attribute, and checks every result transaction in order.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

    import tcw_pkg::*;

    // Generous ceiling on the run. The slowest legal run is far below it, even
    // counting the power-up sweep and a full screen copy for every scroll.
    localparam int CYCLE_LIMIT = 20_000_000;

    // After the final transaction, wait long enough for a whole scroll to
    // finish, so that any stray result still shows up.
    localparam int DRAIN_CYCLES = 2100;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [BYTE_W-1:0] cfg_data = '0;

    // Stimulus and expected results.
    in_item_t  queued_commands [$];
    out_item_t expected_reports [$];

    // Shadow copy of the console: the screen store, the cursor and the
    // attribute that new characters are written with.
    logic [15:0]       shadow_screen [CELLS];
    int                shadow_col = 0;
    int                shadow_row = 0;
    logic [BYTE_W-1:0] shadow_attr = RESET_ATTRIBUTE;

    // Idle rates in percent, changed only while the console is quiet.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Pending attribute write, handed from the sequence to the config driver.
    logic              attr_write_waiting = 1'b0;
    logic [BYTE_W-1:0] attr_write_value = '0;

    int fail_count = 0;
    int cycle_count = 0;

    text_console_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow console
    // ------------------------------------------------------------------------

    // Moves the shadow cursor to the start of the next row. Past the last row
    // the screen shifts up by one row and the bottom row is blanked with the
    // attribute in force now, not the reset attribute.
    task automatic advance_line();
        shadow_col = 0;
        if (shadow_row + 1 >= ROWS)
        begin
            shadow_row = ROWS - 1;
            for (int i = 0; i < CELLS - COLUMNS; i++)
                shadow_screen[ADDR_W'(i)] = shadow_screen[ADDR_W'(i + COLUMNS)];
            for (int c = 0; c < COLUMNS; c++)
                shadow_screen[ADDR_W'((ROWS - 1) * COLUMNS + c)] = {shadow_attr, SPACE_CODE};
        end
        else
        begin
            shadow_row++;
        end
    endtask

    // Applies one input transaction to the shadow console and returns the
    // result the console should report for it.
    task automatic console_step(input in_item_t item, output out_item_t res);
        logic [15:0] stored;
        res = '0;
        if (item.opcode == OP_READ)
        begin
            // Reads leave everything alone; an address past the screen reads
            // back as zero.
            if (item.read_address < CELLS)
            begin
                stored = shadow_screen[item.read_address];
                res.read_char = stored[7:0];
                res.read_attribute = stored[15:8];
            end
        end
        else if (item.char_code == NEWLINE_CODE)
        begin
            advance_line();
        end
        else
        begin
            shadow_screen[ADDR_W'(shadow_row * COLUMNS + shadow_col)] =
                {shadow_attr, item.char_code};
            shadow_col++;
            if (shadow_col >= COLUMNS)
                advance_line();
        end
        res.cursor_position = POS_W'(shadow_row * COLUMNS + shadow_col);
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------

    // Each accepted transaction is run through the shadow console right away,
    // and its result is queued. A new transaction is offered only once the
    // previous one has gone, so valid and payload hold steady until accepted.
    always @(posedge clk)
    begin : item_driver
        out_item_t res;
        if (in_valid && in_ready)
        begin
            console_step(in_data, res);
            expected_reports.push_back(res);
        end
        if (!in_valid || in_ready)
        begin
            if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= queued_commands.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The shadow attribute follows the attribute register at the same edge at
    // which the console takes the write.
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            shadow_attr = cfg_data;
            cfg_valid <= 1'b0;
        end
        else if (!cfg_valid && attr_write_waiting)
        begin
            cfg_data <= attr_write_value;
            cfg_valid <= 1'b1;
            attr_write_waiting = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $realtime, field, want, got);
            fail_count++;
        end
    endtask

    // Results are matched in order against the oldest expectation. The
    // receiver drops ready at random to stall the output register.
    always @(posedge clk)
    begin : result_monitor
        out_item_t want;
        if (out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $realtime, out_data);
                fail_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("cursor_position", int'(want.cursor_position),
                            int'(out_data.cursor_position));
                check_field("read_char", int'(want.read_char),
                            int'(out_data.read_char));
                check_field("read_attribute", int'(want.read_attribute),
                            int'(out_data.read_attribute));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("text_console_writer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic in_item_t make_item(input logic op, input logic [BYTE_W-1:0] code,
                                           input logic [POS_W-1:0] addr);
        in_item_t item;
        item.opcode = op;
        item.char_code = code;
        item.read_address = addr;
        return item;
    endfunction

    // Polls on the falling edge, when every transaction of the rising edge has
    // settled, until nothing is queued, offered or outstanding.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (queued_commands.size() != 0 || in_valid || expected_reports.size() != 0);
    endtask

    task automatic write_attribute(input logic [BYTE_W-1:0] value);
        attr_write_value = value;
        attr_write_waiting = 1'b1;
        do
            @(negedge clk);
        while (attr_write_waiting || cfg_valid);
    endtask

    // Queues about count transactions of console traffic. Most of it is text:
    // short lines ended by a newline, now and then a line long enough to wrap
    // past the row end, so the screen fills and keeps scrolling. Reads of the
    // screen, reads past its end and loose random transactions are mixed in.
    task automatic queue_console_text(input int count);
        int added;
        int pick;
        int len;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(COLUMNS - 2, COLUMNS + 2);
                else
                    len = $urandom_range(0, 12);
                for (int i = 0; i < len; i++)
                    queued_commands.push_back(make_item(OP_PUT,
                                                        BYTE_W'($urandom_range(255)),
                                                        POS_W'($urandom_range(2047))));
                added += len;
                if ($urandom_range(99) < 85)
                begin
                    queued_commands.push_back(make_item(OP_PUT, NEWLINE_CODE,
                                                        POS_W'($urandom_range(2047))));
                    added++;
                end
            end
            else if (pick < 70)
            begin
                // Reads near the bottom, where fresh text and blank rows sit.
                queued_commands.push_back(make_item(OP_READ, BYTE_W'($urandom_range(255)),
                                          POS_W'($urandom_range(CELLS - 2 * COLUMNS,
                                                                CELLS - 1))));
                added++;
            end
            else if (pick < 85)
            begin
                queued_commands.push_back(make_item(OP_READ, BYTE_W'($urandom_range(255)),
                                                    POS_W'($urandom_range(CELLS - 1))));
                added++;
            end
            else if (pick < 92)
            begin
                queued_commands.push_back(make_item(OP_READ, BYTE_W'($urandom_range(255)),
                                                    POS_W'($urandom_range(CELLS, 2047))));
                added++;
            end
            else
            begin
                queued_commands.push_back(make_item(1'($urandom_range(1)),
                                                    BYTE_W'($urandom_range(255)),
                                                    POS_W'($urandom_range(2047))));
                added++;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            shadow_screen[ADDR_W'(i)] = {RESET_ATTRIBUTE, SPACE_CODE};

        // First the sender idles lightly while the receiver stalls often.
        send_idle_pct = 18;
        recv_idle_pct = 63;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset attribute: the first and last cells of the
        // screen, reads past its end up to the largest address, the extreme character
        // codes, two newlines, and reads of what was just written.
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'd0));
        queued_commands.push_back(make_item(OP_READ, 8'hFF, 11'(CELLS - 1)));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'(CELLS)));
        queued_commands.push_back(make_item(OP_READ, 8'hFF, 11'h7FF));
        queued_commands.push_back(make_item(OP_PUT, 8'h00, 11'h7FF));
        queued_commands.push_back(make_item(OP_PUT, 8'hFF, 11'd0));
        queued_commands.push_back(make_item(OP_PUT, 8'h41, 11'h555));
        queued_commands.push_back(make_item(OP_PUT, NEWLINE_CODE, 11'h2AA));
        queued_commands.push_back(make_item(OP_PUT, NEWLINE_CODE, 11'd0));
        queued_commands.push_back(make_item(OP_PUT, SPACE_CODE, 11'd0));
        queued_commands.push_back(make_item(OP_PUT, 8'h7E, 11'd0));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'd0));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'd1));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'd2));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'd3));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'(2 * COLUMNS)));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'(2 * COLUMNS + 1)));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'(2 * COLUMNS + 2)));
        queued_commands.push_back(make_item(OP_READ, 8'h00, 11'(COLUMNS)));
        wait_quiet();

        // Each attribute change lands between phases, with nothing in flight,
        // so the sender also sits out until every result has been taken.
        write_attribute(8'hFF);
        queue_console_text(250);
        wait_quiet();
        write_attribute(8'h00);
        queue_console_text(250);
        wait_quiet();

        // Then the sender idles often and the receiver only lightly.
        send_idle_pct = 63;
        recv_idle_pct = 18;
        write_attribute(BYTE_W'($urandom_range(1, 254)));
        queue_console_text(250);
        wait_quiet();
        write_attribute(8'h4E);
        queue_console_text(250);
        wait_quiet();

        // Finally both sides run flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_attribute(BYTE_W'($urandom_range(255)));
        queue_console_text(250);
        wait_quiet();
        write_attribute(RESET_ATTRIBUTE);
        queue_console_text(250);
        wait_quiet();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("text_console_writer: match");
        else
            $display("text_console_writer: mismatch");
        $finish;
    end

endmodule

[filelist.f]
design/tcw_pkg.sv
design/tcw_datapath.sv
design/tcw_controller.sv
design/text_console_writer.sv
tb/text_console_writer_tb.sv
